[sv/vertex_transform_project_unit_macros.svh]
// assertion macros for the vertex transform and projection unit
// used by vtp_queue and vtp_back, clock clk_i and reset rst_ni assumed
`ifndef VERTEX_TRANSFORM_PROJECT_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vtp assertion failed");
`define VTP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("vtp assertion failed");
`else
`define VTP_ASSERT(lbl, prop)
`define VTP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/vtp_pkg.sv]
// shared constants for the vertex transform and projection unit
// no dependencies
package vtp_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  // quotient bits, one above the 32-bit result to catch overflow
  localparam int unsigned QUOT_BITS     = 33;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_LEFT  = 3'd0,
    REG_ROW0_RIGHT = 3'd1,
    REG_ROW1_LEFT  = 3'd2,
    REG_ROW1_RIGHT = 3'd3,
    REG_ROW2_LEFT  = 3'd4,
    REG_ROW2_RIGHT = 3'd5,
    REG_ROW3_LEFT  = 3'd6,
    REG_ROW3_RIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic push;
    logic full;
  } q_push_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_pop_t;
endpackage

[sv/vtp_front.sv]
// front end: matrix registers, products, clip sums and classification
// depends on vtp_pkg
module vtp_front #(
  parameter int unsigned FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  parameter int unsigned CW        = 66 - FRAC_BITS,
  parameter int unsigned EW        = 4 * CW + 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vtp_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [vtp_pkg::REG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_z_i,
  output vtp_pkg::q_push_t                 q_o,
  input  logic                             q_full_i,
  output logic [EW-1:0]                    entry_o
);
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [vtp_pkg::REG_W-1:0] regs_q [vtp_pkg::NUM_REGS];
  logic signed [31:0] m [4][4];
  logic signed [63:0] prod_q [4][3];
  logic signed [CW-1:0] clip_q [4];
  logic signed [CW-1:0] clip_d [4];
  logic f1_v_q, f2_v_q, adv;
  logic [CW-1:0] mag [4];
  logic [2:0] neg;
  logic fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < vtp_pkg::NUM_REGS; r++) regs_q[r] <= '0;
      regs_q[vtp_pkg::REG_ROW0_LEFT]  <= ONE << 32;
      regs_q[vtp_pkg::REG_ROW1_LEFT]  <= ONE;
      regs_q[vtp_pkg::REG_ROW2_RIGHT] <= ONE << 32;
      regs_q[vtp_pkg::REG_ROW3_RIGHT] <= ONE;
    end else if (cfg_we_i) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m[i][0] = regs_q[2*i][63:32];
      m[i][1] = regs_q[2*i][31:0];
      m[i][2] = regs_q[2*i+1][63:32];
      m[i][3] = regs_q[2*i+1][31:0];
    end
  end

  assign adv        = !(f2_v_q && q_full_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  // one multiplier per matrix element in the first three columns; the fourth column is added
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i][0] <= 64'(m[i][0]) * 64'(vertex_x_i);
        prod_q[i][1] <= 64'(m[i][1]) * 64'(vertex_y_i);
        prod_q[i][2] <= 64'(m[i][2]) * 64'(vertex_z_i);
      end
      clip_q <= clip_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      clip_d[i] = CW'(prod_q[i][0] >>> FRAC_BITS) + CW'(prod_q[i][1] >>> FRAC_BITS)
                + CW'(prod_q[i][2] >>> FRAC_BITS) + CW'(m[i][3]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = clip_q[i][CW-1] ? CW'(-clip_q[i]) : CW'(clip_q[i]);
    end
    for (int i = 0; i < 3; i++) neg[i] = clip_q[i][CW-1] ^ clip_q[3][CW-1];
    fault = (clip_q[3] == '0);
  end

  assign entry_o   = {mag[0], mag[1], mag[2], mag[3], neg, fault};
  assign q_o.push  = f2_v_q && !q_full_i;
  assign q_o.full  = q_full_i;
endmodule

[sv/vtp_queue.sv]
// short queue between the front and back ends
// depends on vtp_pkg and the assertion macro header
`include "vertex_transform_project_unit_macros.svh"
module vtp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = vtp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vtp_pkg::q_push_t wr_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  vtp_pkg::q_pop_t  rd_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;
  logic push, pop;

  assign push    = wr_i.push;
  assign pop     = rd_i.pop && !empty_o;
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  `VTP_ASSERT(a_no_overflow, !(push && full_o))
  `VTP_ASSERT(a_count_bound, cnt_q <= CNTW'(DEPTH))
  `VTP_ASSERT_NEXT(a_push_fills, push && !pop, !empty_o)
endmodule

[sv/vtp_back.sv]
// back end: pipelined restoring divide, saturation and output register
// depends on vtp_pkg and the assertion macro header
`include "vertex_transform_project_unit_macros.svh"
module vtp_back #(
  parameter int unsigned FRAC_BITS = vtp_pkg::FRAC_BITS_DEF,
  parameter int unsigned CW        = 66 - FRAC_BITS,
  parameter int unsigned EW        = 4 * CW + 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [EW-1:0]                      entry_i,
  input  logic                               q_empty_i,
  output vtp_pkg::q_pop_t                    q_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_x_o,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_y_o,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_z_o,
  output logic                               divide_fault_o
);
  localparam int unsigned NS = vtp_pkg::QUOT_BITS;
  localparam int unsigned RW = CW + 1;
  localparam int unsigned QW = vtp_pkg::QUOT_BITS;

  logic          vld_q  [NS+1];
  logic [CW-1:0] a_q    [NS+1][3];
  logic [CW-1:0] b_q    [NS+1];
  logic [RW-1:0] r_q    [NS+1][3];
  logic [QW-1:0] qt_q   [NS+1][3];
  logic [2:0]    ovf_q  [NS+1];
  logic [2:0]    neg_q  [NS+1];
  logic          flt_q  [NS+1];
  logic [RW-1:0] r_d    [NS+1][3];
  logic [QW-1:0] qt_d   [NS+1][3];

  logic adv, out_valid_q, fault_q;
  logic [vtp_pkg::COORD_W-1:0] ndc_q [3];
  logic [CW-1:0] ea [3];
  logic [CW-1:0] eb;
  logic [2:0] eneg;
  logic efault;
  logic [CW-1:0] r0 [3];
  logic [2:0] ovf0;
  logic [vtp_pkg::COORD_W-1:0] res [3];

  assign adv      = !(out_valid_q && out_stall_i);
  assign q_o.pop  = adv;
  assign q_o.empty = q_empty_i;
  assign {ea[0], ea[1], ea[2], eb, eneg, efault} = entry_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r0[c]   = ea[c] >> (QW - FRAC_BITS);
      ovf0[c] = (r0[c] >= eb);
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int K = NS - s;
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic nb;
      logic [RW-1:0] sh;
      if (K >= FRAC_BITS) begin : g_bit
        assign nb = a_q[s-1][c][K-FRAC_BITS];
      end else begin : g_zero
        assign nb = 1'b0;
      end
      assign sh = {r_q[s-1][c][RW-2:0], nb};
      always_comb begin
        if (sh >= {1'b0, b_q[s-1]}) begin
          r_d[s][c]  = sh - {1'b0, b_q[s-1]};
          qt_d[s][c] = {qt_q[s-1][c][QW-2:0], 1'b1};
        end else begin
          r_d[s][c]  = sh;
          qt_d[s][c] = {qt_q[s-1][c][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      r_d[0][c]  = '0;
      qt_d[0][c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !q_empty_i;
      for (int s = 1; s <= NS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        a_q[0][c]  <= ea[c];
        r_q[0][c]  <= RW'(r0[c]);
        qt_q[0][c] <= '0;
      end
      b_q[0]   <= eb;
      ovf_q[0] <= ovf0;
      neg_q[0] <= eneg;
      flt_q[0] <= efault;
      for (int s = 1; s <= NS; s++) begin
        a_q[s]   <= a_q[s-1];
        b_q[s]   <= b_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
        flt_q[s] <= flt_q[s-1];
        r_q[s]   <= r_d[s];
        qt_q[s]  <= qt_d[s];
      end
    end
  end

  // saturate, then apply the sign
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [QW-1:0] lim, mg;
      lim = neg_q[NS][c] ? QW'(33'h0_8000_0000) : QW'(33'h0_7FFF_FFFF);
      mg  = (ovf_q[NS][c] || qt_q[NS][c] > lim) ? lim : qt_q[NS][c];
      res[c] = neg_q[NS][c] ? 32'(-mg) : mg[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vld_q[NS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fault_q <= flt_q[NS];
      for (int c = 0; c < 3; c++) ndc_q[c] <= flt_q[NS] ? '0 : res[c];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ndc_x_o        = ndc_q[0];
  assign ndc_y_o        = ndc_q[1];
  assign ndc_z_o        = ndc_q[2];
  assign divide_fault_o = fault_q;

  `VTP_ASSERT(a_fault_zero, !(out_valid_q && fault_q) ||
    (ndc_q[0] == '0 && ndc_q[1] == '0 && ndc_q[2] == '0))
  `VTP_ASSERT_NEXT(a_hold_last, !adv && vld_q[NS], vld_q[NS])
  `VTP_ASSERT_NEXT(a_hold_out, out_valid_q && out_stall_i, out_valid_q)
endmodule

[sv/vertex_transform_project_unit.sv]
// throughput one vertex per cycle while out_stall_i is low; an input transfer reaches its result
// via two multiply and sum stages, the queue register, 34 divide stages and the output register
// reset clears pipeline valids and the queue, and loads the identity matrix
// depends on vtp_pkg, vtp_front, vtp_queue and vtp_back
module vertex_transform_project_unit #(
  parameter int unsigned FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vtp_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [vtp_pkg::REG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] vertex_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_x_o,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_y_o,
  output logic signed [vtp_pkg::COORD_W-1:0] ndc_z_o,
  output logic                               divide_fault_o
);
  localparam int unsigned CW = 66 - FRAC_BITS;
  localparam int unsigned EW = 4 * CW + 4;

  vtp_pkg::q_push_t wr;
  vtp_pkg::q_pop_t  rd;
  logic full, empty;
  logic [EW-1:0] wdata, rdata;

  vtp_front #(.FRAC_BITS(FRAC_BITS), .CW(CW), .EW(EW)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .q_o(wr), .q_full_i(full), .entry_o(wdata)
  );

  vtp_queue #(.WIDTH(EW), .DEPTH(vtp_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .wr_i(wr), .data_i(wdata), .full_o(full),
    .rd_i(rd), .empty_o(empty), .data_o(rdata)
  );

  vtp_back #(.FRAC_BITS(FRAC_BITS), .CW(CW), .EW(EW)) u_back (
    .clk_i, .rst_ni, .entry_i(rdata), .q_empty_i(empty), .q_o(rd),
    .out_valid_o, .out_stall_i, .ndc_x_o, .ndc_y_o, .ndc_z_o, .divide_fault_o
  );
endmodule

[tb/tb_top.sv]
// self-checking testbench for vertex_transform_project_unit; needs it and vtp_pkg
// predicts untyped ndc results from its own matrix copy; typed rows carry their own
module tb_top;
  localparam int unsigned FRAC      = vtp_pkg::FRAC_BITS_DEF;
  localparam int unsigned COORD_W   = vtp_pkg::COORD_W;
  localparam int unsigned IDX_W     = vtp_pkg::IDX_W;
  localparam int unsigned REG_W     = vtp_pkg::REG_W;
  localparam int unsigned NUM_REGS  = vtp_pkg::NUM_REGS;
  localparam int unsigned LATENCY   = 38;
  localparam int unsigned DOG_LIMIT = 4000;
  localparam int unsigned N_RANDOM  = 1030;
  localparam int unsigned CALM_TAIL = 150;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               fault;
  } ndc_t;

  typedef struct {
    int                 stage;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    bit                 typed;
    ndc_t               want;
  } vec_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, divide_fault_o;
  logic signed [COORD_W-1:0] vertex_x_i, vertex_y_i, vertex_z_i;
  logic signed [COORD_W-1:0] ndc_x_o, ndc_y_o, ndc_z_o;

  logic [REG_W-1:0] matrix [NUM_REGS];
  ndc_t pending_ndc [$];
  bit   cur_typed;
  ndc_t cur_want;
  bit   calm;
  bit   failed;
  int   stall_left;
  int   idle_cycles;

  vertex_transform_project_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [COORD_W-1:0] elem(int i, int j);
    logic [REG_W-1:0] r;
    r = matrix[i * 2 + j / 2];
    return (j % 2) ? r[31:0] : r[63:32];
  endfunction

  function automatic logic [COORD_W-1:0] quotient(logic [63:0] num, logic [63:0] den);
    logic        neg;
    logic [63:0] a, b, ip, q, limit;
    logic [127:0] wide;
    neg   = num[63] ^ den[63];
    a     = num[63] ? -num : num;
    b     = den[63] ? -den : den;
    ip    = a / b;
    wide  = ({64'd0, a} << FRAC) / {64'd0, b};
    limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q     = (ip >= (64'd1 << (32 - FRAC))) ? limit : wide[63:0];
    if (q > limit) q = limit;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic ndc_t project(logic signed [31:0] vx, logic signed [31:0] vy,
                                   logic signed [31:0] vz);
    logic signed [63:0] clip [4];
    logic signed [63:0] prod;
    logic signed [31:0] v [3];
    ndc_t res;
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int i = 0; i < 4; i++) begin
      clip[i] = elem(i, 3);
      for (int j = 0; j < 3; j++) begin
        prod = elem(i, j) * v[j];
        clip[i] = clip[i] + (prod >>> FRAC);
      end
    end
    if (clip[3] == 0) begin
      res = '{x: '0, y: '0, z: '0, fault: 1'b1};
    end else begin
      res.x = quotient(clip[0], clip[3]);
      res.y = quotient(clip[1], clip[3]);
      res.z = quotient(clip[2], clip[3]);
      res.fault = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'h0001_0000;
      4: return 32'h0;
      default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h40_0000) - 32'h20_0000;
    endcase
  endfunction

  // waits until the pipe has drained before a register write
  task automatic wait_idle();
    while (pending_ndc.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(negedge clk_i);
  endtask

  task automatic write_reg(vtp_pkg::reg_idx_e idx, logic [REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    matrix[idx] = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_random_matrix();
    logic [31:0] lo, hi;
    for (int r = 0; r < NUM_REGS; r++) begin
      hi = rand_coeff();
      lo = rand_coeff();
      // keep w well behaved in most phases
      if (r == vtp_pkg::REG_ROW3_LEFT && $urandom_range(0, 2) != 0) begin
        hi = $urandom_range(0, 32'h200) - 32'h100;
        lo = $urandom_range(0, 32'h200) - 32'h100;
      end
      if (r == vtp_pkg::REG_ROW3_RIGHT && $urandom_range(0, 2) != 0) begin
        hi = $urandom_range(0, 32'h200) - 32'h100;
        lo = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      end
      write_reg(vtp_pkg::reg_idx_e'(r), {hi, lo});
    end
  endtask

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed, ndc_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    vertex_x_i = x;
    vertex_y_i = y;
    vertex_z_i = z;
    cur_typed  = typed;
    cur_want   = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // transfer bookkeeping on both channels
  always @(posedge clk_i) begin
    ndc_t e;
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_ndc.push_back(cur_typed ? cur_want : project(vertex_x_i, vertex_y_i, vertex_z_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ndc.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        e = pending_ndc.pop_front();
        if (ndc_x_o !== e.x) begin
          $error("ndc_x expected %h got %h", e.x, ndc_x_o); failed = 1'b1;
        end
        if (ndc_y_o !== e.y) begin
          $error("ndc_y expected %h got %h", e.y, ndc_y_o); failed = 1'b1;
        end
        if (ndc_z_o !== e.z) begin
          $error("ndc_z expected %h got %h", e.z, ndc_z_o); failed = 1'b1;
        end
        if (divide_fault_o !== e.fault) begin
          $error("divide_fault expected %b got %b", e.fault, divide_fault_o); failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam ndc_t FAULT_NDC = '{x: '0, y: '0, z: '0, fault: 1'b1};
  localparam ndc_t NONE      = '{x: '0, y: '0, z: '0, fault: 1'b0};

  vec_row_t vectors [] = '{
    '{0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{0, MAXC, MAXC, MAXC, 1, '{MAXC, MAXC, MAXC, 1'b0}},
    '{0, MINC, MINC, MINC, 1, '{MINC, MINC, MINC, 1'b0}},
    '{0, MAXC, MINC, 32'h0001_0000, 1, '{MAXC, MINC, 32'h0001_0000, 1'b0}},
    '{0, 32'hffff_ffff, 32'h1, 32'hffff_0000, 1, '{32'hffff_ffff, 32'h1, 32'hffff_0000, 1'b0}},
    '{0, 32'h1234_5678, 32'hdead_beef, 32'h0f0f_0f0f, 0, NONE},
    '{1, 32'h0, 32'h0, 32'h0, 1, FAULT_NDC},
    '{1, MAXC, MAXC, MAXC, 1, FAULT_NDC},
    '{1, MINC, MINC, MINC, 1, FAULT_NDC},
    '{1, 32'h5555_aaaa, 32'haaaa_5555, 32'h1, 1, FAULT_NDC},
    '{2, 32'h0, 32'h0, 32'h0, 0, NONE},
    '{2, MAXC, MAXC, MAXC, 0, NONE},
    '{2, MINC, MINC, MINC, 0, NONE},
    '{2, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 0, NONE},
    '{2, 32'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 0, NONE},
    '{2, 32'h0001_0000, 32'h0, 32'h0001_0000, 0, NONE},
    '{2, 32'h7654_3210, 32'h89ab_cdef, 32'h0000_0100, 0, NONE}
  };

  initial begin
    int stage;
    failed = 1'b0; calm = 1'b0; stall_left = 0; idle_cycles = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; out_stall_i = 1'b0;
    vertex_x_i = '0; vertex_y_i = '0; vertex_z_i = '0;
    cur_typed = 1'b0; cur_want = NONE;
    for (int r = 0; r < NUM_REGS; r++) matrix[r] = '0;
    matrix[vtp_pkg::REG_ROW0_LEFT]  = 64'h0001_0000_0000_0000;
    matrix[vtp_pkg::REG_ROW1_LEFT]  = 64'h0000_0000_0001_0000;
    matrix[vtp_pkg::REG_ROW2_RIGHT] = 64'h0001_0000_0000_0000;
    matrix[vtp_pkg::REG_ROW3_RIGHT] = 64'h0000_0000_0001_0000;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    stage = 0;
    foreach (vectors[k]) begin
      if (vectors[k].stage != stage) begin
        in_valid_i = 1'b0;
        stage = vectors[k].stage;
        wait_idle();
        if (stage == 1) begin
          write_reg(vtp_pkg::REG_ROW3_RIGHT, 64'h0);
        end else begin
          // huge gains with tiny and negative w drive saturation
          write_reg(vtp_pkg::REG_ROW0_LEFT,  {MAXC, 32'h0});
          write_reg(vtp_pkg::REG_ROW1_LEFT,  {32'h0, MINC});
          write_reg(vtp_pkg::REG_ROW2_RIGHT, {32'h0001_0000, 32'h7fff_0000});
          write_reg(vtp_pkg::REG_ROW3_LEFT,  {32'h0, 32'h0});
          write_reg(vtp_pkg::REG_ROW3_RIGHT, {32'hffff_0000, 32'h0000_0001});
        end
      end
      send(vectors[k].x, vectors[k].y, vectors[k].z, vectors[k].typed, vectors[k].want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        in_valid_i = 1'b0;
        wait_idle();
        load_random_matrix();
      end
      if (n >= N_RANDOM - CALM_TAIL) calm = 1'b1;
      send(rand_coord(), rand_coord(), rand_coord(), 1'b0, NONE);
    end
    in_valid_i = 1'b0;

    while (pending_ndc.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
